// ----- hw/rtl/yab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yab_pkg
// Shared types, constants and colour conversion helpers for the blend group.
// ----------------------------------------------------------------------------
package yab_pkg;

    localparam int PIXELS      = 8;
    localparam int ALPHA_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 1'b1;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET    = 8'd1;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t r;
        byte_t g;
        byte_t b;
    } rgb_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               blend_mode;
    } cfg_t;

    function automatic byte_t clamp16(input logic signed [15:0] x);
        byte_t res;
        if (x < 0)
            res = 8'd0;
        else if (x > 16'sd255)
            res = 8'd255;
        else
            res = x[7:0];
        return res;
    endfunction

    // YUV -> RGB, BT.601 integer terms with green v weight 47
    function automatic rgb_t yuv2rgb(input byte_t yy, input byte_t uu, input byte_t vv);
        logic signed [19:0] y;
        logic signed [19:0] u;
        logic signed [19:0] v;
        logic signed [19:0] tr;
        logic signed [19:0] tg;
        logic signed [19:0] tb;
        rgb_t c;
        y  = {12'd0, yy};
        u  = {12'd0, uu};
        v  = {12'd0, vv};
        tr = 20'(((42 * y + 153 * v - 20'sd24224) >>> 8) + y + v - 20'sd128);
        tg = 20'(((42 * y - 100 * u + 47 * v + 20'sd2016) >>> 8) + y + 20'sd128 - v);
        tb = 20'(((42 * y + 4 * u - 20'sd5152) >>> 8) + y + 2 * u - 20'sd256);
        c.r = clamp16(tr[15:0]);
        c.g = clamp16(tg[15:0]);
        c.b = clamp16(tb[15:0]);
        return c;
    endfunction

    function automatic byte_t rgb2y(input rgb_t c);
        logic signed [19:0] t;
        t = 20'(((66 * $signed({12'd0, c.r}) + 129 * $signed({12'd0, c.g})
            + 25 * $signed({12'd0, c.b}) - 20'sd24576) >>> 8) + 20'sd112);
        return clamp16(t[15:0]);
    endfunction

    function automatic byte_t rgb2u(input rgb_t c);
        logic signed [19:0] t;
        t = 20'(((112 * $signed({12'd0, c.b}) - 38 * $signed({12'd0, c.r})
            - 74 * $signed({12'd0, c.g}) + 20'sd128) >>> 8) + 20'sd128);
        return clamp16(t[15:0]);
    endfunction

    function automatic byte_t rgb2v(input rgb_t c);
        logic signed [19:0] t;
        t = 20'(((112 * $signed({12'd0, c.r}) - 94 * $signed({12'd0, c.g})
            - 18 * $signed({12'd0, c.b}) + 20'sd128) >>> 8) + 20'sd128);
        return clamp16(t[15:0]);
    endfunction

endpackage

// ----- hw/rtl/yab_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yab_in_if / yab_out_if
// Valid/ready channels for pixel groups and results.
// ----------------------------------------------------------------------------
interface yab_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_top_luma;
    logic [31:0] first_bottom_luma;
    logic [15:0] first_chroma_u;
    logic [15:0] first_chroma_v;
    logic [31:0] second_top_luma;
    logic [31:0] second_bottom_luma;
    logic [15:0] second_chroma_u;
    logic [15:0] second_chroma_v;
    modport source (output valid, first_top_luma, first_bottom_luma, first_chroma_u,
        first_chroma_v, second_top_luma, second_bottom_luma, second_chroma_u,
        second_chroma_v, input ready);
    modport sink (input valid, first_top_luma, first_bottom_luma, first_chroma_u,
        first_chroma_v, second_top_luma, second_bottom_luma, second_chroma_u,
        second_chroma_v, output ready);
endinterface

interface yab_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_top_luma;
    logic [31:0] out_bottom_luma;
    logic [15:0] out_chroma_u;
    logic [15:0] out_chroma_v;
    modport source (output valid, out_top_luma, out_bottom_luma, out_chroma_u,
        out_chroma_v, input ready);
    modport sink (input valid, out_top_luma, out_bottom_luma, out_chroma_u,
        out_chroma_v, output ready);
endinterface

// ----- hw/rtl/yab_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yab_mix
// Alpha mix of one colour channel: fade or rounded blend.
// ----------------------------------------------------------------------------
module yab_mix
    import yab_pkg::*;
(
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  cfg_t       cfg,
    output logic [7:0] m
);
    logic [8:0]  inv;
    logic [16:0] sum;

    assign inv = 9'd256 - {1'b0, cfg.alpha};

    always_comb
    begin
        if (cfg.blend_mode)
            sum = 17'({9'd0, cfg.alpha} * {9'd0, a}) + 17'({8'd0, inv} * {9'd0, b})
                + 17'd128;
        else
            sum = 17'({9'd0, cfg.alpha} * {9'd0, a});
    end

    assign m = sum[15:8];
endmodule

// ----- hw/rtl/yuv420_alpha_blend_group.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_alpha_blend_group
// Alpha fade/blend of one 4x2 YUV420 pixel group, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one transfer carries a 4x2 group of both pictures (second ignored
//         in fade mode).  out : eight luma bytes, U/V of top pixels 1 and 2.
//   cfg : cfg_we/cfg_index/cfg_data; index 0 alpha, 1 blend_mode. Write only
//         while the pipe is empty.
// Pipeline: stage 1 YUV->RGB for all 16 pixels, stage 2 alpha mix (one
//   8x9 multiply pair per channel), stage 3 RGB->YUV into the output
//   register. Throughput one group per clock while out.ready is high.
// Stall: stages advance only when the slot ahead is empty or moving, so a
//   receiver stall backs up through the pipe with nothing lost or repeated;
//   in.ready drops once all three stages hold data and the receiver stalls.
// Reset: valid bits clear, alpha = 1, blend_mode = 1.
// ----------------------------------------------------------------------------
module yuv420_alpha_blend_group
    import yab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    yab_in_if.sink                in_ch,
    yab_out_if.source             out_ch
);
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha      <= ALPHA_RESET;
            cfg_reg.blend_mode <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALPHA:      cfg_reg.alpha      <= cfg_data;
                REG_BLEND_MODE: cfg_reg.blend_mode <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // stage valids and advance enables
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    assign en3 = !v3_reg || out_ch.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ch.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_ch.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // stage 1: convert every pixel of both pictures
    rgb_t a_next [PIXELS];
    rgb_t b_next [PIXELS];
    rgb_t a_reg  [PIXELS];
    rgb_t b_reg  [PIXELS];
    rgb_t m_next [PIXELS];
    rgb_t m_reg  [PIXELS];

    always_comb
    begin
        for (int p = 0; p < PIXELS; p++)
        begin
            a_next[p] = yuv2rgb(
                (p < 4) ? in_ch.first_top_luma[(p%4)*8 +: 8]
                        : in_ch.first_bottom_luma[(p%4)*8 +: 8],
                in_ch.first_chroma_u[((p%4)/2)*8 +: 8],
                in_ch.first_chroma_v[((p%4)/2)*8 +: 8]);
            b_next[p] = yuv2rgb(
                (p < 4) ? in_ch.second_top_luma[(p%4)*8 +: 8]
                        : in_ch.second_bottom_luma[(p%4)*8 +: 8],
                in_ch.second_chroma_u[((p%4)/2)*8 +: 8],
                in_ch.second_chroma_v[((p%4)/2)*8 +: 8]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // stage 2: alpha mix, three lanes per pixel
    for (genvar p = 0; p < PIXELS; p++)
    begin : g_mix
        yab_mix u_r (.a(a_reg[p].r), .b(b_reg[p].r), .cfg(cfg_reg), .m(m_next[p].r));
        yab_mix u_g (.a(a_reg[p].g), .b(b_reg[p].g), .cfg(cfg_reg), .m(m_next[p].g));
        yab_mix u_b (.a(a_reg[p].b), .b(b_reg[p].b), .cfg(cfg_reg), .m(m_next[p].b));
    end

    always_ff @(posedge clk)
    begin
        if (en2)
            m_reg <= m_next;
    end

    // stage 3: back to YUV into the output register
    logic [31:0] top_next, bot_next, top_reg, bot_reg;
    logic [15:0] u_next, v_next, u_reg, v_reg;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            top_next[p*8 +: 8] = rgb2y(m_reg[p]);
            bot_next[p*8 +: 8] = rgb2y(m_reg[p+4]);
        end
        u_next = {rgb2u(m_reg[2]), rgb2u(m_reg[1])};
        v_next = {rgb2v(m_reg[2]), rgb2v(m_reg[1])};
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            u_reg   <= u_next;
            v_reg   <= v_next;
        end
    end

    assign out_ch.valid           = v3_reg;
    assign out_ch.out_top_luma    = top_reg;
    assign out_ch.out_bottom_luma = bot_reg;
    assign out_ch.out_chroma_u    = u_reg;
    assign out_ch.out_chroma_v    = v_reg;

    // a stalled result holds its slot
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(top_reg))
        else $error("result dropped under stall");
    // input refused only when the whole pipe is full
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> v1_reg && v2_reg && v3_reg)
        else $error("bubble not filled");
    // an accepted group reaches stage 1
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v1_reg)
        else $error("accepted group lost");
endmodule
